FILE: design/sorted_key_table_lookup_top_macros.svh
// Assertion macros shared by the lookup block.
`ifndef SORTED_KEY_TABLE_LOOKUP_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, checked once reset has been released.
`define SKTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked once reset has been released.
`define SKTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sktl_pkg.sv
package sktl_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 17;
  localparam int ENTRY_W     = 64;
  localparam int MATCH_W     = 16;
  localparam int SNAP_HALF   = 4;
  localparam int SCAN_LIMIT  = 9;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PROBE = 1'b1;

  typedef struct packed {
    logic [31:0]      prim;
    logic [15:0]      sec;
    logic [CNT_W-1:0] count;
  } probe_req_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] index;
    logic [7:0]         first;
    logic [7:0]         second;
  } probe_res_t;

endpackage

FILE: design/sktl_ram.sv
module sktl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/sktl_search.sv
`include "sorted_key_table_lookup_top_macros.svh"

module sktl_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  sktl_pkg::probe_req_t              req,
  output logic                              busy,
  output logic [sktl_pkg::IDX_W-1:0]        rd_addr,
  input  logic [sktl_pkg::ENTRY_W-1:0]      rd_data,
  output logic                              res_valid,
  output sktl_pkg::probe_res_t              res
);

  localparam int CW = sktl_pkg::CNT_W;
  localparam int IW = sktl_pkg::IDX_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_CMP, ST_SCAN} state_t;

  state_t               state_r, state_nxt;
  logic [31:0]          kp_r, kp_nxt;
  logic [15:0]          ks_r, ks_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        start_r, start_nxt;
  logic [CW-1:0]        end_r, end_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        scan_i_r, scan_i_nxt;
  logic                 pend_r, pend_nxt;
  logic [CW-1:0]        pend_idx_r, pend_idx_nxt;
  logic                 res_valid_r, res_valid_nxt;
  sktl_pkg::probe_res_t res_r, res_nxt;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_c;
  logic [CW:0]   hi_sum;
  logic [CW-1:0] snap_lo, snap_hi;
  logic [31:0]   e_prim;
  logic [15:0]   e_sec;

  assign mid_sum = {1'b0, start_r} + {1'b0, end_r};
  assign mid_c   = mid_sum[CW:1];
  assign hi_sum  = {1'b0, mid_r} + (CW + 1)'(sktl_pkg::SNAP_HALF);
  assign snap_lo = (mid_r >= CW'(sktl_pkg::SNAP_HALF)) ?
                   (mid_r - CW'(sktl_pkg::SNAP_HALF)) : '0;
  assign snap_hi = (hi_sum < {1'b0, cnt_r}) ? hi_sum[CW-1:0] : cnt_r;
  assign e_prim  = rd_data[63:32];
  assign e_sec   = rd_data[31:16];

  always_comb begin
    rd_addr = '0;
    case (state_r)
      ST_ISSUE: rd_addr = mid_c[IW-1:0];
      ST_SCAN:  rd_addr = scan_i_r[IW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    logic [CW-1:0] new_s;
    logic [CW-1:0] new_e;
    logic          issue;
    new_s         = start_r;
    new_e         = end_r;
    issue         = 1'b0;
    state_nxt     = state_r;
    kp_nxt        = kp_r;
    ks_nxt        = ks_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    scan_i_nxt    = scan_i_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          kp_nxt    = req.prim;
          ks_nxt    = req.sec;
          cnt_nxt   = req.count;
          start_nxt = '0;
          end_nxt   = req.count;
          if (req.count == '0) begin
            // An empty table answers at once with a miss.
            res_valid_nxt = 1'b1;
            res_nxt       = '0;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        mid_nxt   = mid_c;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (e_prim < kp_r) begin
          new_s = mid_r;
          new_e = end_r;
        end else if (e_prim > kp_r) begin
          new_s = start_r;
          new_e = mid_r;
        end else begin
          // Primary key hit: narrow to a small window around the midpoint.
          new_s = snap_lo;
          new_e = snap_hi;
        end
        start_nxt = new_s;
        end_nxt   = new_e;
        if ((new_e - new_s) < CW'(sktl_pkg::SCAN_LIMIT)) begin
          scan_i_nxt = new_s;
          pend_nxt   = 1'b0;
          state_nxt  = ST_SCAN;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_SCAN: begin
        // Reads are issued back to back; each beat of data is checked in the cycle after its read.
        issue        = (scan_i_r < end_r);
        pend_nxt     = issue;
        pend_idx_nxt = scan_i_r;
        if (issue) begin
          scan_i_nxt = scan_i_r + CW'(1);
        end
        if (pend_r && (e_prim == kp_r) && (e_sec == ks_r)) begin
          res_valid_nxt = 1'b1;
          res_nxt.found  = 1'b1;
          res_nxt.index  = sktl_pkg::MATCH_W'(pend_idx_r);
          res_nxt.first  = rd_data[15:8];
          res_nxt.second = rd_data[7:0];
          pend_nxt       = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (!issue && !pend_r) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      end_r       <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
    kp_r       <= kp_nxt;
    ks_r       <= ks_nxt;
    cnt_r      <= cnt_nxt;
    mid_r      <= mid_nxt;
    scan_i_r   <= scan_i_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  `SKTL_ASSERT_NOW(a_strobe_when_idle, res_valid_r, state_r == ST_IDLE, "result strobe during a search")
  `SKTL_ASSERT_NEXT(a_probe_starts, (state_r == ST_IDLE) && go && (req.count != '0),
                    state_r == ST_ISSUE, "probe of a non-empty table did not start a search")
  `SKTL_ASSERT_NOW(a_miss_zero, res_valid_r && !res_r.found,
                   (res_r.index == '0) && (res_r.first == '0) && (res_r.second == '0),
                   "miss reported with non-zero payload")
  `SKTL_ASSERT_NOW(a_window_in_table, state_r != ST_IDLE,
                   (start_r <= end_r) && (end_r <= cnt_r), "search window outside the table")
  `SKTL_ASSERT_NOW(a_scan_bounded, state_r == ST_SCAN,
                   (scan_i_r <= end_r) && ((end_r - start_r) < CW'(sktl_pkg::SCAN_LIMIT)),
                   "scan ran past its window")

endmodule

FILE: design/sorted_key_table_lookup_top.sv
// Sorted key table lookup.
// Items enter on the in_ ports and are taken when start is high while busy is low.
// A load beat (in_req_type low) writes one 64-bit entry at in_entry_index and
// gives no result, and busy stays low. A probe beat splits in_probe_key into a
// primary key (bits 63..32) and a secondary key (bits 31..16), halves the window
// over the first cfg entries (capped at the table depth), then scans at most
// eight entries for the first match of both keys. Busy stays high for the whole
// search. Each halving step reads then compares through the single table read
// port. A full 65536-entry table needs at most 13 halving steps before the scan
// of up to eight entries. The result is on the ports in the first cycle that
// busy is low again, when the next beat may already be taken. A probe of an
// empty table gives its miss in the cycle after the beat without raising busy.
// The result appears on the out_ ports for exactly one cycle with out_valid high;
// the receiver must take it then, as there is no back-pressure.
// cfg_we writes the entry count from cfg_wdata; the user must see that it is
// written only while idle, as the block does not enforce it. Synchronous reset
// clears the count and the sequencer; table contents are kept and are undefined
// until loaded.
module sorted_key_table_lookup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [15:0] in_entry_index,
  input  logic [31:0] in_entry_primary_key,
  input  logic [15:0] in_entry_secondary_key,
  input  logic [7:0]  in_entry_first_value,
  input  logic [7:0]  in_entry_second_value,
  input  logic [63:0] in_probe_key,
  output logic        out_valid,
  output logic        out_found,
  output logic [15:0] out_match_index,
  output logic [7:0]  out_match_first_value,
  output logic [7:0]  out_match_second_value,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  logic [sktl_pkg::CFG_W-1:0]   entry_count_r;
  logic [31:0]                  count_ext;
  logic [sktl_pkg::CNT_W-1:0]   count_clamp;
  logic                         accept;
  logic                         probe_go;
  logic                         wr_en;
  logic [sktl_pkg::IDX_W-1:0]   wr_addr;
  logic [sktl_pkg::ENTRY_W-1:0] wr_data;
  logic [sktl_pkg::IDX_W-1:0]   rd_addr;
  logic [sktl_pkg::ENTRY_W-1:0] rd_data;
  sktl_pkg::probe_req_t         req;
  sktl_pkg::probe_res_t         res;
  logic                         res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  assign count_ext   = 32'(entry_count_r);
  assign count_clamp = (count_ext > 32'(sktl_pkg::TABLE_DEPTH)) ?
                       sktl_pkg::CNT_W'(sktl_pkg::TABLE_DEPTH) :
                       sktl_pkg::CNT_W'(count_ext);

  assign accept   = start && !busy;
  assign probe_go = accept && (in_req_type == sktl_pkg::REQ_PROBE);
  assign wr_en    = accept && (in_req_type == sktl_pkg::REQ_LOAD) &&
                    (32'(in_entry_index) < 32'(sktl_pkg::TABLE_DEPTH));
  assign wr_addr  = sktl_pkg::IDX_W'(in_entry_index);
  assign wr_data  = {in_entry_primary_key, in_entry_secondary_key,
                     in_entry_first_value, in_entry_second_value};

  assign req.prim  = in_probe_key[63:32];
  assign req.sec   = in_probe_key[31:16];
  assign req.count = count_clamp;

  sktl_ram #(
    .WIDTH(sktl_pkg::ENTRY_W),
    .DEPTH(sktl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sktl_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (probe_go),
    .req       (req),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid              = res_valid;
  assign out_found              = res.found;
  assign out_match_index        = res.index;
  assign out_match_first_value  = res.first;
  assign out_match_second_value = res.second;

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned          TOTAL_BEATS   = 1650;
  localparam int unsigned          SETTLE_CYCLES = 4;
  localparam int unsigned          BIG_PROBES    = 8;
  localparam sktl_pkg::probe_res_t NO_MATCH      = '0;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_PROBE} row_kind_t;

  // A load row carries the entry image in word, a probe row the search key,
  // and a count row the new entry count.
  typedef struct {
    row_kind_t            kind;
    logic [15:0]          index;
    logic [63:0]          word;
    bit                   typed;
    sktl_pkg::probe_res_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [15:0] in_entry_index;
  logic [31:0] in_entry_primary_key;
  logic [15:0] in_entry_secondary_key;
  logic [7:0]  in_entry_first_value;
  logic [7:0]  in_entry_second_value;
  logic [63:0] in_probe_key;
  logic        out_valid;
  logic        out_found;
  logic [15:0] out_match_index;
  logic [7:0]  out_match_first_value;
  logic [7:0]  out_match_second_value;
  logic        cfg_we;
  logic [16:0] cfg_wdata;

  sorted_key_table_lookup_top uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_req_type            (in_req_type),
    .in_entry_index         (in_entry_index),
    .in_entry_primary_key   (in_entry_primary_key),
    .in_entry_secondary_key (in_entry_secondary_key),
    .in_entry_first_value   (in_entry_first_value),
    .in_entry_second_value  (in_entry_second_value),
    .in_probe_key           (in_probe_key),
    .out_valid              (out_valid),
    .out_found              (out_found),
    .out_match_index        (out_match_index),
    .out_match_first_value  (out_match_first_value),
    .out_match_second_value (out_match_second_value),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata)
  );

  logic [63:0]                entry_image [0:sktl_pkg::TABLE_DEPTH-1];
  bit                         written [0:sktl_pkg::TABLE_DEPTH-1];
  logic [sktl_pkg::CFG_W-1:0] entry_count_shadow;
  int unsigned                window_lo;
  int unsigned                window_hi;
  sktl_pkg::probe_res_t       pending_results [$];
  stim_row_t                  directed_rows [$];
  sktl_pkg::probe_res_t       oldest;
  int unsigned                beats = 0;
  int unsigned                probes = 0;
  int unsigned                hits = 0;
  int unsigned                count_writes = 0;
  int unsigned                mismatches = 0;
  bit                         steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(100_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned clamped_count();
    return (entry_count_shadow > sktl_pkg::TABLE_DEPTH) ? sktl_pkg::TABLE_DEPTH
                                                        : entry_count_shadow;
  endfunction

  // Halving search followed by a short scan, as the block does it.
  function automatic sktl_pkg::probe_res_t lookup_probe(logic [63:0] key);
    sktl_pkg::probe_res_t res;
    int unsigned n, lo, hi, mid, i;
    logic [31:0] kp;
    logic [15:0] ks;
    logic [63:0] e;
    res = NO_MATCH;
    n = clamped_count();
    kp = key[63:32];
    ks = key[31:16];
    lo = 0;
    hi = n;
    if (n != 0) begin
      do begin
        mid = (lo + hi) / 2;
        e = entry_image[mid];
        if (e[63:32] < kp) begin
          lo = mid;
        end else if (e[63:32] > kp) begin
          hi = mid;
        end else begin
          lo = (mid >= sktl_pkg::SNAP_HALF) ? mid - sktl_pkg::SNAP_HALF : 0;
          hi = (mid + sktl_pkg::SNAP_HALF < n) ? mid + sktl_pkg::SNAP_HALF : n;
        end
      end while (hi - lo >= sktl_pkg::SCAN_LIMIT);
      for (i = lo; i < hi; i++) begin
        e = entry_image[i];
        if (!res.found && e[63:32] == kp && e[31:16] == ks) begin
          res.found  = 1'b1;
          res.index  = i[15:0];
          res.first  = e[15:8];
          res.second = e[7:0];
        end
      end
    end
    window_lo = lo;
    window_hi = hi;
    return res;
  endfunction

  // Entry in key order that the large-table part loads at a position.
  function automatic logic [63:0] filler_entry(int unsigned i);
    logic [31:0] prim;
    prim = (i == sktl_pkg::TABLE_DEPTH - 1) ? 32'hFFFF_FFFF : {i[15:2], 18'h0};
    return {prim, 16'(i * 40503), 8'(i), 8'(i >> 8)};
  endfunction

  // First position that a probe for key would read while it holds nothing yet,
  // or the table depth when every read lands on a loaded entry. The whole scan
  // window counts, as the block may read one entry past a match.
  function automatic int unsigned first_unloaded(logic [63:0] key);
    int unsigned n, lo, hi, mid, i;
    logic [31:0] kp;
    logic [63:0] e;
    n = clamped_count();
    kp = key[63:32];
    lo = 0;
    hi = n;
    if (n == 0) return sktl_pkg::TABLE_DEPTH;
    do begin
      mid = (lo + hi) / 2;
      if (!written[mid]) return mid;
      e = entry_image[mid];
      if (e[63:32] < kp) begin
        lo = mid;
      end else if (e[63:32] > kp) begin
        hi = mid;
      end else begin
        lo = (mid >= sktl_pkg::SNAP_HALF) ? mid - sktl_pkg::SNAP_HALF : 0;
        hi = (mid + sktl_pkg::SNAP_HALF < n) ? mid + sktl_pkg::SNAP_HALF : n;
      end
    end while (hi - lo >= sktl_pkg::SCAN_LIMIT);
    for (i = lo; i < hi; i++) begin
      if (!written[i]) return i;
    end
    return sktl_pkg::TABLE_DEPTH;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] wanted);
    $display("tb: %s mismatch at %0t ns: got %0h, expected %0h", field, $time, got, wanted);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", 64'(out_match_index), 64'h0);
      end else begin
        oldest = pending_results.pop_front();
        if (out_found === 1'b1) hits++;
        if (out_found !== oldest.found)
          report_mismatch("found", 64'(out_found), 64'(oldest.found));
        if (out_match_index !== oldest.index)
          report_mismatch("index", 64'(out_match_index), 64'(oldest.index));
        if (out_match_first_value !== oldest.first)
          report_mismatch("first value", 64'(out_match_first_value), 64'(oldest.first));
        if (out_match_second_value !== oldest.second)
          report_mismatch("second value", 64'(out_match_second_value), 64'(oldest.second));
      end
    end
  end

  // Offers one beat, at times with a random gap in front of it unless idling is off.
  task automatic issue_beat(logic req, logic [15:0] index, logic [63:0] entry,
                            logic [63:0] key, bit typed, sktl_pkg::probe_res_t want);
    int unsigned gap;
    sktl_pkg::probe_res_t predicted;
    if (!steady && $urandom_range(0, 99) < 33) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    start                  <= 1'b1;
    in_req_type            <= req;
    in_entry_index         <= index;
    in_entry_primary_key   <= entry[63:32];
    in_entry_secondary_key <= entry[31:16];
    in_entry_first_value   <= entry[15:8];
    in_entry_second_value  <= entry[7:0];
    in_probe_key           <= key;
    do @(posedge clk); while (busy !== 1'b0);
    beats++;
    if (req == sktl_pkg::REQ_LOAD) begin
      entry_image[index] = entry;
      written[index]     = 1'b1;
    end else begin
      probes++;
      predicted = lookup_probe(key);
      pending_results.push_back(typed ? want : predicted);
    end
  endtask

  // Stops offering beats and waits until the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_count(logic [sktl_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    entry_count_shadow = value;
    count_writes++;
  endtask

  task automatic add_row(row_kind_t kind, logic [15:0] index, logic [63:0] word,
                         bit typed = 1'b0, sktl_pkg::probe_res_t want = '0);
    stim_row_t r;
    r.kind  = kind;
    r.index = index;
    r.word  = word;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // Probes the large table, first loading every entry that the search would read.
  task automatic big_probe(logic [63:0] key);
    int unsigned pos;
    pos = first_unloaded(key);
    while (pos < sktl_pkg::TABLE_DEPTH) begin
      issue_beat(sktl_pkg::REQ_LOAD, 16'(pos), filler_entry(pos), {$urandom, $urandom},
                 1'b0, NO_MATCH);
      pos = first_unloaded(key);
    end
    issue_beat(sktl_pkg::REQ_PROBE, 16'($urandom), {$urandom, $urandom}, key, 1'b0, NO_MATCH);
  endtask

  // Mostly probes for keys that are in the table, with the odd stray load and
  // the odd pause until every result is back.
  task automatic probe_stream(int unsigned n_probes, int unsigned n);
    int unsigned k, pick;
    logic [15:0] idx;
    logic [63:0] e;
    logic [63:0] key;
    for (k = 0; k < n_probes; k++) begin
      if ($urandom_range(0, 99) < 3) settle();
      if ($urandom_range(0, 99) < 8) begin
        idx = (n != 0 && $urandom_range(0, 1) == 1) ? 16'($urandom_range(0, n - 1))
                                                   : 16'($urandom);
        issue_beat(sktl_pkg::REQ_LOAD, idx, {$urandom, $urandom}, {$urandom, $urandom},
                   1'b0, NO_MATCH);
      end else begin
        pick = $urandom_range(0, 99);
        if (n == 0 || pick >= 80) begin
          key = {$urandom, $urandom};
        end else begin
          e = entry_image[$urandom_range(0, n - 1)];
          key = {e[63:32], (pick < 60) ? e[31:16] : 16'($urandom), 16'($urandom)};
        end
        issue_beat(sktl_pkg::REQ_PROBE, 16'($urandom), {$urandom, $urandom}, key,
                   1'b0, NO_MATCH);
      end
    end
  endtask

  // Loads a sorted table of n entries, perhaps spoils its order, then probes it.
  task automatic run_phase(int unsigned n, bit tight_keys, bit scramble);
    int unsigned j;
    logic [32:0] acc;
    logic [31:0] step_max;
    logic [15:0] sec;
    step_max = 32'hFFFF_FFFF / (n + 1);
    acc = tight_keys ? {1'b0, $urandom} : 33'($urandom_range(0, step_max));
    for (j = 0; j < n; j++) begin
      sec = tight_keys ? 16'($urandom_range(0, 3)) : 16'($urandom);
      issue_beat(sktl_pkg::REQ_LOAD, 16'(j),
                 {acc[32] ? 32'hFFFF_FFFF : acc[31:0], sec, 8'($urandom), 8'($urandom)},
                 {$urandom, $urandom}, 1'b0, NO_MATCH);
      acc = acc + (tight_keys ? 33'($urandom_range(0, 1)) : 33'($urandom_range(0, step_max)));
    end
    if (scramble && n != 0) begin
      for (j = 0; j < $urandom_range(1, 3); j++) begin
        issue_beat(sktl_pkg::REQ_LOAD, 16'($urandom_range(0, n - 1)), {$urandom, $urandom},
                   {$urandom, $urandom}, 1'b0, NO_MATCH);
      end
    end
    settle();
    write_count(sktl_pkg::CFG_W'(n));
    probe_stream($urandom_range(10, 40), n);
  endtask

  initial begin
    int unsigned i, n, mode, phase, big_n;
    int unsigned big_counts [4] = '{65536, 131071, 65535, 65537};
    logic [63:0] big_e;
    logic [63:0] big_key;
    rst_n                  = 1'b0;
    start                  = 1'b0;
    in_req_type            = sktl_pkg::REQ_LOAD;
    in_entry_index         = '0;
    in_entry_primary_key   = '0;
    in_entry_secondary_key = '0;
    in_entry_first_value   = '0;
    in_entry_second_value  = '0;
    in_probe_key           = '0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    entry_count_shadow     = '0;
    window_lo              = 0;
    window_hi              = 0;
    for (i = 0; i < sktl_pkg::TABLE_DEPTH; i++) begin
      entry_image[i] = '0;
      written[i]     = 1'b0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The count is still zero from reset, so nothing can match.
    add_row(ROW_PROBE, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NO_MATCH);
    add_row(ROW_LOAD, 16'd0, {32'h0000_0000, 16'h0000, 8'h00, 8'h00});
    add_row(ROW_LOAD, 16'd1, {32'h0000_0005, 16'h1234, 8'hAA, 8'hFF});
    add_row(ROW_LOAD, 16'd2, {32'h0000_0005, 16'hFFFF, 8'hFF, 8'h01});
    add_row(ROW_LOAD, 16'd3, {32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF});
    add_row(ROW_CFG, 16'h0, 64'd4);
    add_row(ROW_PROBE, 16'h0, {32'h0000_0000, 16'h0000, 16'hFFFF}, 1'b1,
            sktl_pkg::probe_res_t'{1'b1, 16'd0, 8'h00, 8'h00});
    add_row(ROW_PROBE, 16'h0, {32'h0000_0005, 16'hFFFF, 16'h0000}, 1'b1,
            sktl_pkg::probe_res_t'{1'b1, 16'd2, 8'hFF, 8'h01});
    add_row(ROW_PROBE, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            sktl_pkg::probe_res_t'{1'b1, 16'd3, 8'hFF, 8'hFF});
    add_row(ROW_PROBE, 16'h0, {32'h0000_0005, 16'h1234, 16'h5A5A});
    add_row(ROW_PROBE, 16'h0, {32'h0000_0005, 16'h1235, 16'hA5A5});
    add_row(ROW_PROBE, 16'h0, {32'h0000_0003, 16'h1234, 16'h0000});
    add_row(ROW_PROBE, 16'h0, {32'hFFFF_FFFF, 16'h0000, 16'h0000});
    add_row(ROW_CFG, 16'h0, 64'd0);
    add_row(ROW_PROBE, 16'h0, 64'h0, 1'b1, NO_MATCH);
    // A run of one primary key, with a larger key at the front that breaks
    // the order: the run's last entry lies outside the snapped window and is missed,
    // and the out-of-place entry is never reached.
    for (i = 0; i < 10; i++) begin
      add_row(ROW_LOAD, 16'(i), {(i == 0) ? 32'd9 : 32'd7, 16'(i), 8'(i + 8'h40), 8'(i)});
    end
    add_row(ROW_CFG, 16'h0, 64'd10);
    add_row(ROW_PROBE, 16'h0, {32'd7, 16'd9, 16'h0000});
    add_row(ROW_PROBE, 16'h0, {32'd9, 16'd0, 16'h0000});

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_CFG: begin
          settle();
          write_count(directed_rows[r].word[sktl_pkg::CFG_W-1:0]);
        end
        ROW_LOAD: begin
          issue_beat(sktl_pkg::REQ_LOAD, directed_rows[r].index, directed_rows[r].word,
                     {$urandom, $urandom}, 1'b0, NO_MATCH);
        end
        default: begin
          issue_beat(sktl_pkg::REQ_PROBE, 16'($urandom), {$urandom, $urandom},
                     directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
        end
      endcase
    end

    // Counts near, at and beyond the full depth. Only the entries that each search
    // reads are loaded, in key order with the top entry at the largest key;
    // the first count runs without gaps.
    foreach (big_counts[c]) begin
      settle();
      steady = (c == 0);
      write_count(sktl_pkg::CFG_W'(big_counts[c]));
      big_n = clamped_count();
      for (i = 0; i < BIG_PROBES; i++) begin
        mode = $urandom_range(0, 99);
        big_e = filler_entry($urandom_range(0, big_n - 1));
        if (mode < 15) begin
          big_key = 64'hFFFF_FFFF_FFFF_FFFF;
        end else if (mode < 35) begin
          big_key = {$urandom, $urandom};
        end else begin
          big_key = {big_e[63:32], (mode < 75) ? big_e[31:16] : 16'($urandom),
                     16'($urandom)};
        end
        big_probe(big_key);
      end
    end
    steady = 1'b0;

    phase = 0;
    while (beats < TOTAL_BEATS) begin
      steady = (phase >= 6 && phase < 11);
      mode = $urandom_range(0, 99);
      if (mode < 5) n = 0;
      else if (mode < 75) n = $urandom_range(1, 24);
      else if (mode < 95) n = $urandom_range(25, 200);
      else n = $urandom_range(201, 1000);
      run_phase(n, $urandom_range(0, 1) == 1, $urandom_range(0, 9) == 0);
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (60) @(posedge clk);
    $display("tb: %0d beats accepted, %0d of them probes, %0d probes hit an entry",
             beats, probes, hits);
    $display("tb: %0d entry counts set, from an empty table to beyond the full depth",
             count_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
